FILE: rtl/rsl_pkg.sv
// Run-slice line generator: shared types and constants.
// Payload words, command and status groups, line kinds and controller states.
// No dependencies.
package rsl_pkg;

   localparam int CoordBits = 12;
   localparam int LenBits   = CoordBits + 1;
   localparam int ErrBits   = CoordBits + 2;
   localparam int ColorBits = 8;

   typedef enum logic {
      CmdStart = 1'b0,
      CmdNext  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KindXMajor = 2'd0,
      KindYMajor = 2'd1,
      KindHoriz  = 2'd2,
      KindVert   = 2'd3
   } line_kind_type;

   typedef enum logic [1:0] {
      StIdle   = 2'd0,
      StSetup  = 2'd1,
      StDivide = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic signed [CoordBits-1:0] x_a;
      logic signed [CoordBits-1:0] y_a;
      logic signed [CoordBits-1:0] x_b;
      logic signed [CoordBits-1:0] y_b;
      logic [ColorBits-1:0]        color_luma;
      logic [ColorBits-1:0]        color_cb;
      logic [ColorBits-1:0]        color_cr;
   } req_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] run_x;
      logic signed [CoordBits-1:0] run_y;
      logic [LenBits-1:0]          run_length;
      logic                        run_vertical;
      logic                        x_goes_left;
      logic [ColorBits-1:0]        out_luma;
      logic [ColorBits-1:0]        out_cb;
      logic [ColorBits-1:0]        out_cr;
      logic                        last_run;
      logic                        no_line_error;
   } rsp_type;

   typedef struct packed {
      logic load_start;
      logic do_next;
      logic do_setup;
      logic div_start;
      logic do_finish;
   } ctl_type;

   typedef struct packed {
      logic special;
      logic div_done;
   } stat_type;

endpackage

FILE: rtl/run_slice_line_generator.sv
// Run-slice line generator, top level.
// Joins rsl_control and rsl_datapath; depends on rsl_pkg.
//
// A word is taken when start is high and busy is low. A next-run word gives
// its result in the next cycle on rsp_word and rsp_strobe; busy stays low, so
// next-run words may come every cycle. A start word raises busy: the endpoints
// are ordered as the word is taken, the setup state finds the deltas and the
// line kind, then, for lines that are neither horizontal nor vertical, a serial
// divider produces one quotient bit per cycle; the first run is registered in
// the setup state for a horizontal or vertical line, else when the divider is
// done. Results cannot stall: each is valid only while rsp_strobe is high.
module run_slice_line_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rsl_pkg::req_type req_word,
   output logic             busy,
   output logic             rsp_strobe,
   output rsl_pkg::rsp_type rsp_word
);

   rsl_pkg::ctl_type  ctl;
   rsl_pkg::stat_type stat;

   rsl_control u_control (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_word.cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   rsl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req        (req_word),
      .stat       (stat),
      .rsp        (rsp_word),
      .rsp_strobe (rsp_strobe)
   );

   a_next_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_word.cmd == rsl_pkg::CmdNext) |=> rsp_strobe)
      else $error("next-run word gave no result");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_word.cmd == rsl_pkg::CmdStart) |=> busy && !rsp_strobe)
      else $error("start word did not raise busy");

   a_done_answers: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("start finished without a result");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.no_line_error |->
         (rsp_word.run_length == '0) && !rsp_word.last_run)
      else $error("error result carries run data");

endmodule

FILE: rtl/rsl_divider.sv
// Run-slice line generator: serial restoring divider, one quotient bit per cycle.
// Computes major / minor and the remainder for the run setup.
// Depends on rsl_pkg.
module rsl_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rsl_pkg::CoordBits-1:0] dividend,
   input  logic [rsl_pkg::CoordBits-1:0] divisor,
   output logic [rsl_pkg::CoordBits-1:0] quotient,
   output logic [rsl_pkg::CoordBits-1:0] remainder,
   output logic                          done
);

   localparam int W       = rsl_pkg::CoordBits;
   localparam int CntBits = $clog2(W + 1);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    dvs_ff, dvs_in;

   logic [W:0]      shifted;
   logic [W:0]      diff;
   logic            fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + CntBits'(1);
         if (cnt_ff == CntBits'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/rsl_datapath.sv
// Run-slice line generator: datapath with line state, run stepping and result word.
// Holds endpoints, error term and position; instantiates rsl_divider.
// Depends on rsl_pkg and rsl_divider.
module rsl_datapath (
   input  logic              clock,
   input  logic              reset,
   input  rsl_pkg::ctl_type  ctl,
   input  rsl_pkg::req_type  req,
   output rsl_pkg::stat_type stat,
   output rsl_pkg::rsp_type  rsp,
   output logic              rsp_strobe
);

   localparam int C  = rsl_pkg::CoordBits;
   localparam int LB = rsl_pkg::LenBits;
   localparam int EB = rsl_pkg::ErrBits;
   localparam int CB = rsl_pkg::ColorBits;

   logic signed [C-1:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [3*CB-1:0]     color_ff, color_in;
   logic                active_ff, active_in;
   rsl_pkg::line_kind_type kind_ff, kind_in;
   logic [C-1:0]        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                left_ff, left_in;
   logic [C-1:0]        minor_ff, minor_in;
   logic [C-1:0]        whole_ff, whole_in;
   logic [C:0]          adj_up_ff, adj_up_in, adj_dn_ff, adj_dn_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic [C-1:0]        runs_left_ff, runs_left_in;
   logic [C-1:0]        final_ff, final_in;
   rsl_pkg::rsp_type    rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   logic signed [C:0]   dx;
   logic [C:0]          dx_mag;
   logic                dx_neg;
   logic [C-1:0]        adx;
   logic [C:0]          dy_wide;
   logic [C-1:0]        dy;
   logic                x_major;
   logic [C-1:0]        major;
   logic [C-1:0]        minor;

   logic [C-1:0]        quo;
   logic [C-1:0]        rem;
   logic                div_done;

   logic signed [EB-1:0] err_sum;
   logic                err_pos;
   logic [LB-1:0]       next_len;
   logic [C-1:0]        half_plus;
   logic [LB-1:0]       init_len;
   logic signed [EB-1:0] odd_add;
   logic signed [EB-1:0] err0;

   logic                emit;
   logic                emit_last;
   logic [LB-1:0]       emit_len;
   logic [C-1:0]        step;

   rsl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.div_start),
      .dividend  (major),
      .divisor   (minor),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   always_comb begin
      dx      = {xe_ff[C-1], xe_ff} - {xs_ff[C-1], xs_ff};
      dx_neg  = dx[C];
      dx_mag  = dx_neg ? ((C+1)'(0) - dx) : dx;
      adx     = dx_mag[C-1:0];
      dy_wide = {ye_ff[C-1], ye_ff} - {ys_ff[C-1], ys_ff};
      dy      = dy_wide[C-1:0];
      x_major = adx >= dy;
      major   = x_major ? adx : dy;
      minor   = x_major ? dy : adx;
      stat.special  = (adx == '0) || (dy == '0);
      stat.div_done = div_done;

      err_sum  = err_ff + $signed({1'b0, adj_up_ff});
      err_pos  = !err_sum[EB-1] && (err_sum != '0);
      next_len = {1'b0, whole_ff} + LB'(err_pos);

      half_plus = {1'b0, quo[C-1:1]} + C'(1);
      init_len  = ((rem == '0) && !quo[0]) ? {2'b00, quo[C-1:1]} : {1'b0, half_plus};
      odd_add   = quo[0] ? $signed({2'b00, minor_ff}) : $signed(EB'(0));
      err0      = $signed({2'b00, rem}) - $signed({1'b0, minor_ff, 1'b0}) + odd_add;

      emit      = 1'b0;
      emit_last = 1'b0;
      emit_len  = init_len;
      if (ctl.do_finish) begin
         emit = 1'b1;
      end else if (ctl.do_next && active_ff) begin
         emit = 1'b1;
         if (runs_left_ff != '0) begin
            emit_len = next_len;
         end else begin
            emit_len  = {1'b0, final_ff};
            emit_last = 1'b1;
         end
      end
      step = emit_len[C-1:0];

      xs_in        = xs_ff;
      ys_in        = ys_ff;
      xe_in        = xe_ff;
      ye_in        = ye_ff;
      color_in     = color_ff;
      active_in    = active_ff;
      kind_in      = kind_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      left_in      = left_ff;
      minor_in     = minor_ff;
      whole_in     = whole_ff;
      adj_up_in    = adj_up_ff;
      adj_dn_in    = adj_dn_ff;
      err_in       = err_ff;
      runs_left_in = runs_left_ff;
      final_in     = final_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;

      if (ctl.load_start) begin
         color_in = {req.color_luma, req.color_cb, req.color_cr};
         if (req.y_a > req.y_b) begin
            xs_in = req.x_b;
            ys_in = req.y_b;
            xe_in = req.x_a;
            ye_in = req.y_a;
         end else begin
            xs_in = req.x_a;
            ys_in = req.y_a;
            xe_in = req.x_b;
            ye_in = req.y_b;
         end
      end

      if (ctl.do_setup) begin
         active_in = 1'b0;
         pos_x_in  = xs_ff;
         pos_y_in  = ys_ff;
         minor_in  = minor;
         left_in   = (adx == '0) ? 1'b0 : dx_neg;
         rsp_in.run_x         = xs_ff;
         rsp_in.run_y         = ys_ff;
         rsp_in.out_luma      = color_ff[3*CB-1:2*CB];
         rsp_in.out_cb        = color_ff[2*CB-1:CB];
         rsp_in.out_cr        = color_ff[CB-1:0];
         rsp_in.last_run      = 1'b1;
         rsp_in.no_line_error = 1'b0;
         if (adx == '0) begin
            kind_in              = rsl_pkg::KindVert;
            rsp_in.run_length    = {1'b0, dy} + LB'(1);
            rsp_in.run_vertical  = 1'b1;
            rsp_in.x_goes_left   = 1'b0;
            strobe_in            = 1'b1;
         end else if (dy == '0) begin
            kind_in              = rsl_pkg::KindHoriz;
            rsp_in.run_length    = {1'b0, adx} + LB'(1);
            rsp_in.run_vertical  = 1'b0;
            rsp_in.x_goes_left   = dx_neg;
            strobe_in            = 1'b1;
         end else begin
            kind_in = x_major ? rsl_pkg::KindXMajor : rsl_pkg::KindYMajor;
         end
      end

      if (ctl.do_finish) begin
         active_in    = 1'b1;
         whole_in     = quo;
         adj_up_in    = {rem, 1'b0};
         adj_dn_in    = {minor_ff, 1'b0};
         err_in       = err0;
         final_in     = half_plus;
         runs_left_in = minor_ff - C'(1);
      end

      if (ctl.do_next && !active_ff) begin
         rsp_in               = '0;
         rsp_in.no_line_error = 1'b1;
         strobe_in            = 1'b1;
      end

      if (ctl.do_next && active_ff) begin
         if (runs_left_ff != '0) begin
            runs_left_in = runs_left_ff - C'(1);
            err_in       = err_pos ? (err_sum - $signed({1'b0, adj_dn_ff})) : err_sum;
         end else begin
            active_in = 1'b0;
         end
      end

      if (emit) begin
         rsp_in.run_x         = pos_x_ff;
         rsp_in.run_y         = pos_y_ff;
         rsp_in.run_length    = emit_len;
         rsp_in.run_vertical  = (kind_ff == rsl_pkg::KindYMajor);
         rsp_in.x_goes_left   = left_ff;
         rsp_in.out_luma      = color_ff[3*CB-1:2*CB];
         rsp_in.out_cb        = color_ff[2*CB-1:CB];
         rsp_in.out_cr        = color_ff[CB-1:0];
         rsp_in.last_run      = emit_last;
         rsp_in.no_line_error = 1'b0;
         strobe_in            = 1'b1;
         if (kind_ff == rsl_pkg::KindXMajor) begin
            pos_x_in = left_ff ? (pos_x_ff - step) : (pos_x_ff + step);
            pos_y_in = pos_y_ff + C'(1);
         end else begin
            pos_y_in = pos_y_ff + step;
            pos_x_in = left_ff ? (pos_x_ff - C'(1)) : (pos_x_ff + C'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
      xs_ff        <= xs_in;
      ys_ff        <= ys_in;
      xe_ff        <= xe_in;
      ye_ff        <= ye_in;
      color_ff     <= color_in;
      kind_ff      <= kind_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      left_ff      <= left_in;
      minor_ff     <= minor_in;
      whole_ff     <= whole_in;
      adj_up_ff    <= adj_up_in;
      adj_dn_ff    <= adj_dn_in;
      err_ff       <= err_in;
      runs_left_ff <= runs_left_in;
      final_ff     <= final_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

FILE: rtl/rsl_control.sv
// Run-slice line generator: controller state machine.
// Sequences start setup and the divide; issues commands to rsl_datapath.
// Depends on rsl_pkg.
module rsl_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rsl_pkg::cmd_type  req_cmd,
   input  rsl_pkg::stat_type stat,
   output rsl_pkg::ctl_type  ctl,
   output logic              busy
);

   rsl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsl_pkg::StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = (state_ff != rsl_pkg::StIdle);
      case (state_ff)
         rsl_pkg::StIdle: begin
            if (start) begin
               if (req_cmd == rsl_pkg::CmdStart) begin
                  ctl.load_start = 1'b1;
                  state_in       = rsl_pkg::StSetup;
               end else begin
                  ctl.do_next = 1'b1;
               end
            end
         end
         rsl_pkg::StSetup: begin
            ctl.do_setup = 1'b1;
            if (stat.special) begin
               state_in = rsl_pkg::StIdle;
            end else begin
               ctl.div_start = 1'b1;
               state_in      = rsl_pkg::StDivide;
            end
         end
         rsl_pkg::StDivide: begin
            if (stat.div_done) begin
               ctl.do_finish = 1'b1;
               state_in      = rsl_pkg::StIdle;
            end
         end
         default: begin
            state_in = rsl_pkg::StIdle;
         end
      endcase
   end

endmodule
